// ===== rtl/core/config_text_tokenizer_unit_assert.svh =====
// assertion macros shared by the tokenizer rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef CONFIG_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CTT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ctt_pkg.sv =====
// shared types, constants and helpers of the text tokenizer
// depends on nothing
package ctt_pkg;

   // token length limit and derived widths
   localparam int MAX_TOKEN_LEN = 512;
   localparam int LEN_W = $clog2(MAX_TOKEN_LEN);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LEN - 1);

   // line counter
   localparam int LINE_W = 16;
   localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // character codes
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // token kind codes
   typedef enum logic [2:0] {
      KIND_NAME = 3'd0,
      KIND_INT = 3'd1,
      KIND_STR = 3'd2,
      KIND_EQ = 3'd3,
      KIND_COMMA = 3'd4,
      KIND_END = 3'd5
   } kind_type;

   // one result item
   typedef struct packed {
      kind_type kind;
      logic [7:0] token_char;
      logic has_char;
      logic first;
      logic last;
      logic too_long;
      logic unterminated;
      logic [LINE_W-1:0] line;
   } token_type;

   // up to two result items made by one character
   typedef struct packed {
      logic [1:0] count;
      token_type item0;
      token_type item1;
   } scan_out_type;

   // build a result item; text is zero when no character is carried
   function automatic token_type make_item(input kind_type kind, input logic [7:0] ch,
                                           input logic has, input logic first,
                                           input logic last, input logic tl,
                                           input logic un, input logic [LINE_W-1:0] line);
      token_type t;
      t.kind = kind;
      t.token_char = has ? ch : 8'h00;
      t.has_char = has;
      t.first = first;
      t.last = last;
      t.too_long = tl;
      t.unterminated = un;
      t.line = line;
      return t;
   endfunction

endpackage

// ===== rtl/core/ctt_ifs.sv =====
// valid/ready channel interfaces for characters in and token items out
// depends on nothing

// character channel
interface ctt_req_if;
   logic valid;
   logic ready;
   logic [7:0] char_in;
   logic end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

// token item channel
interface ctt_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] token_kind;
   logic [7:0] token_char;
   logic has_char;
   logic token_first;
   logic token_last;
   logic too_long;
   logic unterminated;
   logic [15:0] line_out;

   modport source (output valid, output token_kind, output token_char, output has_char,
                   output token_first, output token_last, output too_long,
                   output unterminated, output line_out, input ready);
   modport sink (input valid, input token_kind, input token_char, input has_char,
                 input token_first, input token_last, input too_long,
                 input unterminated, input line_out, output ready);
endinterface

// ===== rtl/core/ctt_scanner.sv =====
// scanner state machine: classifies one character per step, makes up to two items
// depends on ctt_pkg and config_text_tokenizer_unit_assert.svh
`include "config_text_tokenizer_unit_assert.svh"

module ctt_scanner (
   input logic clock,
   input logic reset,
   input logic step,
   input logic [7:0] char_in,
   input logic end_of_input,
   output ctt_pkg::scan_out_type scan_out
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_NAME = 3'd1,
      MODE_INT = 3'd2,
      MODE_STR = 3'd3,
      MODE_CMT = 3'd4
   } mode_type;

   mode_type mode_ff, mode_in;
   logic [ctt_pkg::LEN_W-1:0] len_ff, len_in;
   logic [ctt_pkg::LINE_W-1:0] line_ff, line_in;
   logic ovf_ff, ovf_in;

   logic eoi, is_letter, is_digit, is_name_char, cont, classify, emit1, emit2;
   ctt_pkg::kind_type run_kind;
   ctt_pkg::token_type item1, item2;

   // character classes
   assign eoi = end_of_input || (char_in == ctt_pkg::CHAR_NUL);
   assign is_letter = ((char_in >= 8'h41) && (char_in <= 8'h5A)) ||
                      ((char_in >= 8'h61) && (char_in <= 8'h7A));
   assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
   assign is_name_char = is_letter || is_digit || (char_in == ctt_pkg::CHAR_UNDERSCORE);
   assign run_kind = (mode_ff == MODE_NAME) ? ctt_pkg::KIND_NAME : ctt_pkg::KIND_INT;

   // next state and items
   always_comb begin
      mode_in = mode_ff;
      len_in = len_ff;
      line_in = line_ff;
      ovf_in = ovf_ff;
      classify = 1'b0;
      cont = 1'b0;
      emit1 = 1'b0;
      emit2 = 1'b0;
      item1 = '0;
      item2 = '0;

      // finish or extend the token in progress
      unique case (mode_ff) inside
         MODE_NAME, MODE_INT: begin
            cont = !eoi && ((mode_ff == MODE_NAME) ? is_name_char : is_digit);
            if (cont) begin
               if (len_ff < ctt_pkg::LEN_LIMIT) begin
                  len_in = len_ff + 1'b1;
                  emit1 = 1'b1;
                  item1 = ctt_pkg::make_item(run_kind, char_in, 1'b1, 1'b0, 1'b0,
                                             1'b0, 1'b0, line_ff);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               emit1 = 1'b1;
               item1 = ctt_pkg::make_item(run_kind, 8'h00, 1'b0, 1'b0, 1'b1,
                                          ovf_ff, 1'b0, line_ff);
               mode_in = MODE_IDLE;
               classify = 1'b1;
            end
         end
         MODE_STR: begin
            if (eoi) begin
               emit1 = 1'b1;
               item1 = ctt_pkg::make_item(ctt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1,
                                          ovf_ff, 1'b1, line_ff);
               mode_in = MODE_IDLE;
               classify = 1'b1;
            end else if (char_in == ctt_pkg::CHAR_QUOTE) begin
               emit1 = 1'b1;
               item1 = ctt_pkg::make_item(ctt_pkg::KIND_STR, 8'h00, 1'b0, 1'b0, 1'b1,
                                          ovf_ff, 1'b0, line_ff);
               mode_in = MODE_IDLE;
            end else if (len_ff < ctt_pkg::LEN_LIMIT) begin
               len_in = len_ff + 1'b1;
               emit1 = 1'b1;
               item1 = ctt_pkg::make_item(ctt_pkg::KIND_STR, char_in, 1'b1, 1'b0, 1'b0,
                                          1'b0, 1'b0, line_ff);
            end else begin
               ovf_in = 1'b1;
            end
         end
         MODE_CMT: begin
            if (eoi) begin
               mode_in = MODE_IDLE;
               classify = 1'b1;
            end else if (char_in == ctt_pkg::CHAR_LF) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            classify = 1'b1;
         end
      endcase

      // start a new token from the current character
      if (classify) begin
         if (eoi) begin
            emit2 = 1'b1;
            item2 = ctt_pkg::make_item(ctt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1,
                                       1'b0, 1'b0, line_ff);
            mode_in = MODE_IDLE;
            len_in = '0;
            ovf_in = 1'b0;
            line_in = ctt_pkg::LINE_FIRST;
         end else if (is_letter || is_digit) begin
            mode_in = is_letter ? MODE_NAME : MODE_INT;
            len_in = ctt_pkg::LEN_W'(1);
            ovf_in = 1'b0;
            emit2 = 1'b1;
            item2 = ctt_pkg::make_item(is_letter ? ctt_pkg::KIND_NAME : ctt_pkg::KIND_INT,
                                       char_in, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, line_ff);
         end else if (char_in == ctt_pkg::CHAR_QUOTE) begin
            mode_in = MODE_STR;
            len_in = '0;
            ovf_in = 1'b0;
            emit2 = 1'b1;
            item2 = ctt_pkg::make_item(ctt_pkg::KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0,
                                       1'b0, 1'b0, line_ff);
         end else if (char_in == ctt_pkg::CHAR_HASH) begin
            mode_in = MODE_CMT;
         end else if (char_in == ctt_pkg::CHAR_EQUALS) begin
            emit2 = 1'b1;
            item2 = ctt_pkg::make_item(ctt_pkg::KIND_EQ, 8'h00, 1'b0, 1'b1, 1'b1,
                                       1'b0, 1'b0, line_ff);
         end else if (char_in == ctt_pkg::CHAR_COMMA) begin
            emit2 = 1'b1;
            item2 = ctt_pkg::make_item(ctt_pkg::KIND_COMMA, 8'h00, 1'b0, 1'b1, 1'b1,
                                       1'b0, 1'b0, line_ff);
         end
      end

      // saturating line count, newline counted after its items
      if (!eoi && (char_in == ctt_pkg::CHAR_LF) && (line_ff != ctt_pkg::LINE_MAX)) begin
         line_in = line_ff + 1'b1;
      end
   end

   // pack items so the earlier one leads
   always_comb begin
      scan_out.count = {1'b0, emit1} + {1'b0, emit2};
      scan_out.item0 = emit1 ? item1 : item2;
      scan_out.item1 = item2;
   end

   // state registers, updated only on an accepted character
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff <= '0;
         line_ff <= ctt_pkg::LINE_FIRST;
         ovf_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         line_ff <= line_in;
         ovf_ff <= ovf_in;
      end
   end

   // checks
   `CTT_ASSERT_NOW(a_line_nonzero, clock, reset, 1'b1, line_ff != '0,
                   "line count reached zero")
   `CTT_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= ctt_pkg::LEN_LIMIT,
                   "token length beyond limit")
   `CTT_ASSERT_NEXT(a_end_restart, clock, reset, step && eoi,
                    (mode_ff == MODE_IDLE) && (line_ff == ctt_pkg::LINE_FIRST),
                    "end of input did not restart the scanner")

endmodule

// ===== rtl/core/ctt_result_queue.sv =====
// four-entry result queue: takes up to two items per cycle while it has room for two, delivers one
// depends on ctt_pkg and config_text_tokenizer_unit_assert.svh
`include "config_text_tokenizer_unit_assert.svh"

module ctt_result_queue (
   input logic clock,
   input logic reset,
   input logic push_en,
   input ctt_pkg::scan_out_type push_data,
   output logic space_ok,
   input logic pop_ready,
   output logic head_valid,
   output ctt_pkg::token_type head_item
);

   ctt_pkg::token_type entries_ff [ctt_pkg::QUEUE_DEPTH];
   logic [ctt_pkg::QPTR_W-1:0] head_ff, head_in, tail, tail1;
   logic [ctt_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [1:0] push_n;
   logic pop;

   // room for the worst case of two items
   assign space_ok = count_ff <= ctt_pkg::QCNT_W'(ctt_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head_item = entries_ff[head_ff];
   assign pop = head_valid && pop_ready;
   assign push_n = push_en ? push_data.count : 2'd0;

   // pointers and fill level
   always_comb begin
      tail = head_ff + count_ff[ctt_pkg::QPTR_W-1:0];
      tail1 = tail + 1'b1;
      head_in = pop ? head_ff + 1'b1 : head_ff;
      count_in = count_ff + ctt_pkg::QCNT_W'(push_n) - ctt_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries_ff[tail] <= push_data.item0;
      end
      if (push_n == 2'd2) begin
         entries_ff[tail1] <= push_data.item1;
      end
   end

   // checks
   `CTT_ASSERT_NOW(a_no_overfill, clock, reset, push_n != 2'd0, space_ok,
                   "push into a queue without room")
   `CTT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   count_ff <= ctt_pkg::QCNT_W'(ctt_pkg::QUEUE_DEPTH),
                   "queue fill level beyond depth")
   `CTT_ASSERT_NEXT(a_pair_fill, clock, reset, (push_n == 2'd2) && !pop,
                    count_ff == $past(count_ff) + ctt_pkg::QCNT_W'(2),
                    "two-item push lost an item")

endmodule

// ===== rtl/core/config_text_tokenizer_unit.sv =====
// Items: an item reaches the result port the cycle after its character is taken when
// no older item waits; a character's second item follows once the first is popped.
// Throughput: one character per cycle; the input stalls only while the four-entry
// result queue holds three or more items.
// Reset: synchronous, active high; scanner idle, line 1, result queue empty.
// depends on ctt_pkg, ctt_ifs, ctt_scanner and ctt_result_queue
module config_text_tokenizer_unit (
   input logic clock,
   input logic reset,
   ctt_req_if.sink req_chan,
   ctt_rsp_if.source rsp_chan
);

   ctt_pkg::scan_out_type scan_out;
   ctt_pkg::token_type head_item;
   logic space_ok, step;

   // character accepted on the character channel
   assign req_chan.ready = space_ok;
   assign step = req_chan.valid && space_ok;

   ctt_scanner u_scanner (
      .clock(clock),
      .reset(reset),
      .step(step),
      .char_in(req_chan.char_in),
      .end_of_input(req_chan.end_of_input),
      .scan_out(scan_out)
   );

   ctt_result_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_en(step),
      .push_data(scan_out),
      .space_ok(space_ok),
      .pop_ready(rsp_chan.ready),
      .head_valid(rsp_chan.valid),
      .head_item(head_item)
   );

   // result channel payload
   assign rsp_chan.token_kind = head_item.kind;
   assign rsp_chan.token_char = head_item.token_char;
   assign rsp_chan.has_char = head_item.has_char;
   assign rsp_chan.token_first = head_item.first;
   assign rsp_chan.token_last = head_item.last;
   assign rsp_chan.too_long = head_item.too_long;
   assign rsp_chan.unterminated = head_item.unterminated;
   assign rsp_chan.line_out = head_item.line;

endmodule
